[hdl/qdr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdr_pkg - shared types and constants of the quadrature decoder
// Command and register codes, sequencer states, divider request/response
// structs and the quadrature transition table.
// ----------------------------------------------------------------------------
package qdr_pkg;

    // item commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SWAP_PINS = 2'd0;
    localparam logic [1:0] REG_HALF_STEP = 2'd1;
    localparam logic [1:0] REG_STEPS_REV = 2'd2;
    localparam logic [1:0] REG_MIN_RPM   = 2'd3;

    // divider width: every dividend is at most one minute in microseconds
    localparam int DIV_W = 26;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_W-1:0] ONE_MINUTE_US   = 26'd60000000;
    localparam logic [7:0]       DEFAULT_STEPS   = 8'd20;
    localparam logic [15:0]      DEFAULT_MIN_RPM = 16'd30;

    // pin pair codes that mark a step
    localparam logic [1:0] PINS_FULL = 2'b11;
    localparam logic [1:0] PINS_ZERO = 2'b00;

    // direction codes
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // read sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_STEP,
        ST_DIV_LIMIT,
        ST_DIV_RPM,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // count change for (last | new << 1), low three bits
    function automatic logic signed [1:0] step_delta(input logic [2:0] idx);
        logic signed [1:0] d;
        d = 2'sd0;
        unique case (idx)
            3'd0: d = 2'sd0;
            3'd1: d = 2'sd1;
            3'd2: d = -2'sd1;
            3'd3: d = 2'sd1;
            3'd4: d = 2'sd1;
            3'd5: d = 2'sd0;
            3'd6: d = 2'sd1;
            3'd7: d = -2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

[hdl/qdr_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdr_divider - shared restoring divider
// One quotient bit per cycle; at the end of a run the quotient is
// shown together with done, which is high for one cycle.
// ----------------------------------------------------------------------------
module qdr_divider
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qdr_pkg::div_req_t req,
    output qdr_pkg::div_rsp_t      rsp
);

    logic [qdr_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [qdr_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [31:0]                   dsr_reg, dsr_next;
    logic [qdr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [qdr_pkg::DIV_W:0]       trial;
    logic                          fits;

    // trial subtraction of one step
    always_comb
    begin
        trial = {rem_reg, quo_reg[qdr_pkg::DIV_W-1]};
        fits  = {5'd0, trial} >= dsr_reg;
    end

    // step control
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = qdr_pkg::DIV_W'(trial - dsr_reg[qdr_pkg::DIV_W:0]);
            end
            else
            begin
                rem_next = trial[qdr_pkg::DIV_W-1:0];
            end
            quo_next = {quo_reg[qdr_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == qdr_pkg::DIV_CNT_W'(qdr_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

[hdl/quadrature_decoder_rpm_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_rpm_core - quadrature decoder with speed measure
// Tracks a wrapping 16-bit position count from A/B samples, stamps full
// cycles and reports scaled count, direction, step flag and rpm on read.
// ----------------------------------------------------------------------------
//  channel | dir | signals                          | contents
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | sample, load or read item
//  m_      | out | m_tvalid m_tready m_tdata         | read result
//  cfg_    | in  | cfg_valid cfg_ready cfg_index/data| register write
//
//  sample and load items keep the sequencer in idle; s_tready stays high in idle
//  a read item holds s_tready low until its result is handed over: it
//  runs the shared divider for the per-step time, the slow limit and the
//  rpm, launching the first run on acceptance and each next run on the
//  done of the one before; the rpm division is skipped when the period is
//  too long
//  the result sits in an output register; a stalled m_ holds only the
//  final hand-over of the next read, not its divisions
//  reset clears the count, time stamps, flag and registers to defaults
// ----------------------------------------------------------------------------
module quadrature_decoder_rpm_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // pin_a_level, pin_b_level, time_us[31:0],
                                        // load_value[15:0], zero fill
    input  wire logic [1:0]  s_tuser,   // command[1:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // step_value[14:0], step_flag, direction[1:0],
                                        // rpm[25:0], zero fill

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // input field views
    logic               in_a;
    logic               in_b;
    logic [31:0]        in_time;
    logic signed [15:0] in_load;
    logic [1:0]         in_cmd;

    assign in_a    = s_tdata[0];
    assign in_b    = s_tdata[1];
    assign in_time = s_tdata[33:2];
    assign in_load = s_tdata[49:34];
    assign in_cmd  = s_tuser;

    // registers
    qdr_pkg::state_t           state_reg, state_next;
    logic                      swap_reg, swap_next;
    logic                      half_reg, half_next;
    logic [7:0]                spr_reg, spr_next;
    logic [15:0]               minrpm_reg, minrpm_next;
    logic [1:0]                last_pins_reg, last_pins_next;
    logic signed [15:0]        raw_count_reg, raw_count_next;
    logic [31:0]               last_time_reg, last_time_next;
    logic [31:0]               prev_time_reg, prev_time_next;
    logic                      pending_reg, pending_next;
    logic signed [15:0]        read_count_reg, read_count_next;
    logic [14:0]               res_step_reg, res_step_next;
    logic                      res_flag_reg, res_flag_next;
    logic [1:0]                res_dir_reg, res_dir_next;
    logic [31:0]               period_reg, period_next;
    logic [qdr_pkg::DIV_W-1:0] per_step_reg, per_step_next;
    logic [qdr_pkg::DIV_W-1:0] rpm_reg, rpm_next;
    logic                      out_valid_reg, out_valid_next;
    logic [47:0]               out_data_reg, out_data_next;

    // control
    logic               in_acc;
    logic               cfg_acc;
    logic               deliver;
    logic               take_rpm;
    logic [7:0]         steps_eff;
    logic [15:0]        minr_eff;
    logic [31:0]        prev_eff;
    logic [31:0]        period_div;
    logic [1:0]         pins;
    logic [2:0]         delta_idx;
    logic signed [15:0] delta;

    qdr_pkg::div_req_t  div_req;
    qdr_pkg::div_rsp_t  div_rsp;

    qdr_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready  = (state_reg == qdr_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // operand defaults and pin decode
    always_comb
    begin
        steps_eff  = (spr_reg != 8'd0) ? spr_reg : qdr_pkg::DEFAULT_STEPS;
        minr_eff   = (minrpm_reg != 16'd0) ? minrpm_reg : qdr_pkg::DEFAULT_MIN_RPM;
        prev_eff   = (prev_time_reg != 32'd0) ? prev_time_reg : 32'd1;
        period_div = (period_reg != 32'd0) ? period_reg : 32'd1;
        take_rpm   = period_reg < {6'd0, div_rsp.quotient};
        pins       = swap_reg ? {in_a, in_b} : {in_b, in_a};
        delta_idx  = {1'b0, last_pins_reg} | {pins, 1'b0};
        delta      = 16'(qdr_pkg::step_delta(delta_idx));
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qdr_pkg::ST_IDLE:
            begin
                if (in_acc && in_cmd == qdr_pkg::CMD_READ)
                begin
                    state_next = qdr_pkg::ST_DIV_STEP;
                end
            end
            qdr_pkg::ST_DIV_STEP:
            begin
                if (div_rsp.done)
                begin
                    state_next = qdr_pkg::ST_DIV_LIMIT;
                end
            end
            qdr_pkg::ST_DIV_LIMIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = take_rpm ? qdr_pkg::ST_DIV_RPM : qdr_pkg::ST_DELIVER;
                end
            end
            qdr_pkg::ST_DIV_RPM:
            begin
                if (div_rsp.done)
                begin
                    state_next = qdr_pkg::ST_DELIVER;
                end
            end
            qdr_pkg::ST_DELIVER:
            begin
                if (deliver)
                begin
                    state_next = qdr_pkg::ST_IDLE;
                end
            end
            default: state_next = qdr_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: divider launches and result hand-over
    always_comb
    begin
        div_req = '0;
        deliver = 1'b0;
        unique case (state_reg)
            qdr_pkg::ST_IDLE:
            begin
                if (in_acc && in_cmd == qdr_pkg::CMD_READ)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = qdr_pkg::ONE_MINUTE_US;
                    div_req.divisor  = {24'd0, steps_eff};
                end
            end
            qdr_pkg::ST_DIV_STEP:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = {16'd0, minr_eff};
                end
            end
            qdr_pkg::ST_DIV_LIMIT:
            begin
                if (div_rsp.done && take_rpm)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = per_step_reg;
                    div_req.divisor  = period_div;
                end
            end
            qdr_pkg::ST_DIV_RPM:
            begin
                div_req = '0;
            end
            qdr_pkg::ST_DELIVER:
            begin
                deliver = !out_valid_reg || m_tready;
            end
            default: deliver = 1'b0;
        endcase
    end

    // configuration writes
    always_comb
    begin
        swap_next   = swap_reg;
        half_next   = half_reg;
        spr_next    = spr_reg;
        minrpm_next = minrpm_reg;
        if (cfg_acc)
        begin
            unique case (cfg_index)
                qdr_pkg::REG_SWAP_PINS: swap_next   = cfg_data[0];
                qdr_pkg::REG_HALF_STEP: half_next   = cfg_data[0];
                qdr_pkg::REG_STEPS_REV: spr_next    = cfg_data[7:0];
                qdr_pkg::REG_MIN_RPM:   minrpm_next = cfg_data;
                default:                swap_next   = swap_reg;
            endcase
        end
    end

    // count, time stamps and read snapshot
    always_comb
    begin
        last_pins_next  = last_pins_reg;
        raw_count_next  = raw_count_reg;
        last_time_next  = last_time_reg;
        prev_time_next  = prev_time_reg;
        pending_next    = pending_reg;
        read_count_next = read_count_reg;
        res_step_next   = res_step_reg;
        res_flag_next   = res_flag_reg;
        res_dir_next    = res_dir_reg;
        period_next     = period_reg;
        if (in_acc)
        begin
            unique case (in_cmd)
                qdr_pkg::CMD_SAMPLE:
                begin
                    if (pins != last_pins_reg)
                    begin
                        raw_count_next = raw_count_reg + delta;
                        last_pins_next = pins;
                        if (pins == qdr_pkg::PINS_FULL)
                        begin
                            prev_time_next = last_time_reg;
                            last_time_next = in_time;
                            pending_next   = 1'b1;
                        end
                        if (pins == qdr_pkg::PINS_ZERO && half_reg)
                        begin
                            pending_next = 1'b1;
                        end
                    end
                end
                qdr_pkg::CMD_LOAD:
                begin
                    raw_count_next = in_load;
                end
                qdr_pkg::CMD_READ:
                begin
                    res_step_next = half_reg ? 15'(raw_count_reg >>> 1)
                                             : 15'(raw_count_reg >>> 2);
                    res_flag_next = pending_reg;
                    pending_next  = 1'b0;
                    res_dir_next  = qdr_pkg::DIR_IDLE;
                    if (read_count_reg > raw_count_reg)
                    begin
                        res_dir_next    = qdr_pkg::DIR_CCW;
                        read_count_next = raw_count_reg;
                    end
                    else if (read_count_reg < raw_count_reg)
                    begin
                        res_dir_next    = qdr_pkg::DIR_CW;
                        read_count_next = raw_count_reg;
                    end
                    period_next = last_time_reg - prev_eff;
                end
                default: period_next = period_reg;
            endcase
        end
    end

    // division results and output register
    always_comb
    begin
        per_step_next  = per_step_reg;
        rpm_next       = rpm_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (state_reg == qdr_pkg::ST_DIV_STEP && div_rsp.done)
        begin
            per_step_next = div_rsp.quotient;
        end
        if (state_reg == qdr_pkg::ST_DIV_LIMIT && div_rsp.done && !take_rpm)
        begin
            rpm_next = '0;
        end
        if (state_reg == qdr_pkg::ST_DIV_RPM && div_rsp.done)
        begin
            rpm_next = div_rsp.quotient;
        end
        if (deliver)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'd0, rpm_reg, res_dir_reg, res_flag_reg, res_step_reg};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qdr_pkg::ST_IDLE;
            swap_reg       <= 1'b0;
            half_reg       <= 1'b0;
            spr_reg        <= qdr_pkg::DEFAULT_STEPS;
            minrpm_reg     <= qdr_pkg::DEFAULT_MIN_RPM;
            last_pins_reg  <= '0;
            raw_count_reg  <= '0;
            last_time_reg  <= '0;
            prev_time_reg  <= '0;
            pending_reg    <= 1'b0;
            read_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            swap_reg       <= swap_next;
            half_reg       <= half_next;
            spr_reg        <= spr_next;
            minrpm_reg     <= minrpm_next;
            last_pins_reg  <= last_pins_next;
            raw_count_reg  <= raw_count_next;
            last_time_reg  <= last_time_next;
            prev_time_reg  <= prev_time_next;
            pending_reg    <= pending_next;
            read_count_reg <= read_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_step_reg <= res_step_next;
        res_flag_reg <= res_flag_next;
        res_dir_reg  <= res_dir_next;
        period_reg   <= period_next;
        per_step_reg <= per_step_next;
        rpm_reg      <= rpm_next;
        out_data_reg <= out_data_next;
    end

    // a read transaction always starts the per-step division
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_cmd == qdr_pkg::CMD_READ) |=>
            (state_reg == qdr_pkg::ST_DIV_STEP && div_rsp.busy))
    else $error("read did not launch the divider");

    // the divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == qdr_pkg::ST_DIV_STEP ||
                          state_reg == qdr_pkg::ST_DIV_LIMIT ||
                          state_reg == qdr_pkg::ST_DIV_RPM))
    else $error("divider done outside a division state");

    // a new result appears only from the hand-over state
    assert property (@(posedge clk) disable iff (!rst_n)
        (deliver) |=> (m_tvalid && state_reg == qdr_pkg::ST_IDLE))
    else $error("result hand-over lost");

    // no item is taken while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> !s_tready)
    else $error("input accepted during division");

endmodule
`default_nettype wire
